// File: sv/address_keyed_table_with_aging_core_defines.svh
// Assertion macros used by the back end of the address-keyed table RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ADDRESS_KEYED_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define ADDRESS_KEYED_TABLE_WITH_AGING_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define AKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define AKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/akt_pkg.sv
// Shared types and constants for the address-keyed table with aging.
// No dependencies; the top, front and back end files use it by scoped names.
`default_nettype none

package akt_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int STATUS_BITS_DEF   = 64;
  localparam int CMD_FIFO_DEPTH    = 2;
  localparam int RES_FIFO_DEPTH    = 2;

  localparam logic [31:0] TIMEOUT_RESET = 32'd480000;

  // Input opcodes.
  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_SWEEP = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef enum logic [1:0] {
    KIND_STORE,
    KIND_SWEEP,
    KIND_QUERY,
    KIND_NONE
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        now_ms;
    logic [47:0]        dev_addr;
    logic [7:0]         dev_addr_type;
    logic signed [7:0]  signal_level;
    logic [63:0]        status_word;
    logic [2:0]         entry_index;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [2:0]         slot_used;
    logic [3:0]         active_count;
    logic [47:0]        read_addr;
    logic [7:0]         read_addr_type;
    logic signed [7:0]  read_level;
    logic [63:0]        read_status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [31:0]        now_ms;
    logic [47:0]        dev_addr;
    logic [7:0]         dev_addr_type;
    logic signed [7:0]  signal_level;
    logic [63:0]        status_word;
    logic [2:0]         entry_index;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/address_keyed_table_with_aging_core.sv
// Top level of the address-keyed device table with aging.
// Depends on akt_pkg, akt_fifo, akt_front and akt_back.
//
// Usage. Items enter through a queue-style port: an item is taken on a
// rising edge with push high and full low. Opcode 0 stores an entry keyed by
// its 48-bit address, opcode 1 runs an aging sweep, opcode 2 reads one slot.
// Exactly one result comes back per item, in order, on a queue-style port:
// the oldest result sits on out_item while empty is low and leaves on a
// rising edge with pop high. The timeout register is written through
// cfg_we/cfg_wdata, and it should only change while the block is idle.
// Operation. A store or sweep walks every slot through the single read port
// of the slot memory. When idle, the back end takes a command in the cycle
// after it enters the command queue, and the result is on out_item right
// after the back end finishes, if the result queue was empty. Items are
// worked one at a time.
// A two-entry command queue lets new items be accepted while the back end is
// busy, and a two-entry result queue lets work finish while the receiver
// stalls; when that queue is full the back end holds its result and stops.
// Reset clears all active bits, the active count, both queues and loads the
// default timeout of 480000 ms. Slot contents are not cleared and need no
// clearing pass, since a slot's contents are only used while it is active.
`default_nettype none

module address_keyed_table_with_aging_core #(
  parameter int TABLE_ENTRIES = akt_pkg::TABLE_ENTRIES_DEF,
  parameter int STATUS_BITS   = akt_pkg::STATUS_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire akt_pkg::in_item_t in_item,
  output logic                full,
  output logic                empty,
  input  wire logic           pop,
  output akt_pkg::out_item_t  out_item,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata
);

  localparam int CMD_W = $bits(akt_pkg::cmd_t);
  localparam int RES_W = $bits(akt_pkg::out_item_t);

  // Front end to command queue.
  akt_pkg::cmd_t      front_cmd;
  logic               front_push;
  logic               cmd_full;

  // Command queue to back end.
  akt_pkg::cmd_t      back_cmd;
  logic [CMD_W-1:0]   back_cmd_bits;
  logic               cmd_empty;
  logic               cmd_pop;

  // Back end to result queue.
  akt_pkg::out_item_t back_res;
  logic               res_push;
  logic               res_full;
  logic [RES_W-1:0]   res_bits;

  assign back_cmd = back_cmd_bits;
  assign out_item = res_bits;

  // Decode incoming items into commands.
  akt_front #(
    .STATUS_BITS (STATUS_BITS)
  ) u_front (
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .cmd_push (front_push),
    .cmd      (front_cmd),
    .cmd_full (cmd_full)
  );

  // Short queue that decouples acceptance from execution.
  akt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (akt_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (back_cmd_bits),
    .empty (cmd_empty)
  );

  // Table, timeout register and the slot-scanning sequencer.
  akt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .STATUS_BITS   (STATUS_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // Result queue; its head drives the output port directly.
  akt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (akt_pkg::RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty)
  );

endmodule

`default_nettype wire

// File: sv/akt_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
// Used between the front and back ends and for the result channel.
`default_nettype none

module akt_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + CW'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// File: sv/akt_front.sv
// Front end: decodes an input item into an internal command for the back end.
// Depends on akt_pkg for the item and command types.
`default_nettype none

module akt_front #(
  parameter int STATUS_BITS = akt_pkg::STATUS_BITS_DEF
) (
  input  wire logic             push,
  input  wire akt_pkg::in_item_t in_item,
  output logic                  full,
  output logic                  cmd_push,
  output akt_pkg::cmd_t         cmd,
  input  wire logic             cmd_full
);

  localparam logic [63:0] STATUS_MASK = {64{1'b1}} >> (64 - STATUS_BITS);

  assign full     = cmd_full;
  assign cmd_push = push;

  always_comb begin
    cmd.now_ms        = in_item.now_ms;
    cmd.dev_addr      = in_item.dev_addr;
    cmd.dev_addr_type = in_item.dev_addr_type;
    cmd.signal_level  = in_item.signal_level;
    // Only the low STATUS_BITS bits of the payload are kept in the table.
    cmd.status_word   = in_item.status_word & STATUS_MASK;
    cmd.entry_index   = in_item.entry_index;
    unique case (in_item.opcode)
      akt_pkg::OP_STORE: cmd.kind = akt_pkg::KIND_STORE;
      akt_pkg::OP_SWEEP: cmd.kind = akt_pkg::KIND_SWEEP;
      akt_pkg::OP_QUERY: cmd.kind = akt_pkg::KIND_QUERY;
      default:           cmd.kind = akt_pkg::KIND_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/akt_back.sv
// Back end: holds the entry table and timeout register and executes commands.
// Depends on akt_pkg and the assertion macros in the defines header.
`default_nettype none

`include "address_keyed_table_with_aging_core_defines.svh"

module akt_back #(
  parameter int TABLE_ENTRIES = akt_pkg::TABLE_ENTRIES_DEF,
  parameter int STATUS_BITS   = akt_pkg::STATUS_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata,
  input  wire akt_pkg::cmd_t cmd,
  input  wire logic         cmd_empty,
  output logic              cmd_pop,
  output akt_pkg::out_item_t res,
  output logic              res_push,
  input  wire logic         res_full
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  // Control state.
  state_t                   state;
  logic [31:0]              timeout;
  logic [TABLE_ENTRIES-1:0] active;
  logic [CW-1:0]            count;
  logic                     cmp_vld;

  // Per-command working registers.
  akt_pkg::cmd_t            cur;
  logic                     q_hit;
  logic [CW-1:0]            cnt;
  logic [IW-1:0]            cmp_idx;
  logic                     match_found;
  logic [IW-1:0]            match_idx;
  logic                     free_found;
  logic [IW-1:0]            free_idx;

  // Table storage, one read and one write port per array.
  logic [47:0]              key_mem    [TABLE_ENTRIES];
  logic [31:0]              seen_mem   [TABLE_ENTRIES];
  logic [7:0]               type_mem   [TABLE_ENTRIES];
  logic signed [7:0]        level_mem  [TABLE_ENTRIES];
  logic [STATUS_BITS-1:0]   status_mem [TABLE_ENTRIES];
  logic [47:0]              key_rd;
  logic [31:0]              seen_rd;
  logic [7:0]               type_rd;
  logic signed [7:0]        level_rd;
  logic [STATUS_BITS-1:0]   status_rd;

  logic                     rd_en;
  logic [IW-1:0]            rd_addr;
  logic                     q_in_range;
  logic                     q_hit_next;
  logic                     scan_issue;
  logic [31:0]              age;
  logic                     expire;
  logic                     key_hit;
  logic                     free_hit;
  logic [IW-1:0]            slot_sel;
  logic                     store_new;
  logic                     do_store;

  assign cmd_pop    = (state == S_IDLE) && !cmd_empty;
  assign q_in_range = (32'(cmd.entry_index) < 32'(TABLE_ENTRIES));
  assign q_hit_next = (cmd.kind == akt_pkg::KIND_QUERY) && q_in_range &&
                      active[IW'(cmd.entry_index)];
  assign scan_issue = (state == S_SCAN) && (cnt < CW'(TABLE_ENTRIES));
  assign rd_en      = scan_issue || (cmd_pop && q_hit_next);
  assign rd_addr    = (state == S_SCAN) ? cnt[IW-1:0] : IW'(cmd.entry_index);

  // Compare stage works on the entry read in the previous cycle.
  assign age      = cur.now_ms - seen_rd;
  assign expire   = cmp_vld && (cur.kind == akt_pkg::KIND_SWEEP) && active[cmp_idx] &&
                    (timeout != '0) && (age > timeout);
  assign key_hit  = cmp_vld && (cur.kind == akt_pkg::KIND_STORE) && active[cmp_idx] &&
                    (key_rd == cur.dev_addr);
  assign free_hit = cmp_vld && (cur.kind == akt_pkg::KIND_STORE) && !active[cmp_idx];

  // Matching slot first, then the lowest free slot, then slot 0.
  assign slot_sel  = match_found ? match_idx : (free_found ? free_idx : '0);
  assign store_new = (cur.kind == akt_pkg::KIND_STORE) && !active[slot_sel];
  assign res_push  = (state == S_FINISH) && !res_full;
  assign do_store  = res_push && (cur.kind == akt_pkg::KIND_STORE);

  always_comb begin
    res.active_count   = 4'(count + CW'(store_new));
    res.read_addr      = q_hit ? key_rd : '0;
    res.read_addr_type = q_hit ? type_rd : '0;
    res.read_level     = q_hit ? level_rd : '0;
    res.read_status    = q_hit ? 64'(status_rd) : '0;
    unique case (cur.kind)
      akt_pkg::KIND_STORE: begin
        res.ok        = 1'b1;
        res.slot_used = 3'(slot_sel);
      end
      akt_pkg::KIND_SWEEP: begin
        res.ok        = 1'b1;
        res.slot_used = '0;
      end
      akt_pkg::KIND_QUERY: begin
        res.ok        = q_hit;
        res.slot_used = cur.entry_index;
      end
      default: begin
        res.ok        = 1'b0;
        res.slot_used = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      timeout <= akt_pkg::TIMEOUT_RESET;
      active  <= '0;
      count   <= '0;
      cmp_vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          cmp_vld <= 1'b0;
          if (!cmd_empty) begin
            if ((cmd.kind == akt_pkg::KIND_STORE) || (cmd.kind == akt_pkg::KIND_SWEEP)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          cmp_vld <= scan_issue;
          if (expire) begin
            active[cmp_idx] <= 1'b0;
            count           <= count - CW'(1);
          end
          if (cnt == CW'(TABLE_ENTRIES)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!res_full) begin
            state <= S_IDLE;
            if (cur.kind == akt_pkg::KIND_STORE) begin
              active[slot_sel] <= 1'b1;
              count            <= count + CW'(store_new);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur         <= cmd;
      q_hit       <= q_hit_next;
      cnt         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end
    if (state == S_SCAN) begin
      cnt     <= cnt + CW'(1);
      cmp_idx <= cnt[IW-1:0];
      if (key_hit && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= cmp_idx;
      end
      if (free_hit && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_rd    <= key_mem[rd_addr];
      seen_rd   <= seen_mem[rd_addr];
      type_rd   <= type_mem[rd_addr];
      level_rd  <= level_mem[rd_addr];
      status_rd <= status_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      key_mem[slot_sel]    <= cur.dev_addr;
      seen_mem[slot_sel]   <= cur.now_ms;
      type_mem[slot_sel]   <= cur.dev_addr_type;
      level_mem[slot_sel]  <= cur.signal_level;
      status_mem[slot_sel] <= cur.status_word[STATUS_BITS-1:0];
    end
  end

  `AKT_ASSERT_IMP(a_count_tracks_active, 1'b1, $countones(active) == int'(count), "active count out of step with active bits")
  `AKT_ASSERT_NXT(a_store_sets_active, do_store, active[$past(slot_sel)], "stored slot not marked active")
  `AKT_ASSERT_IMP(a_scan_bounded, state == S_SCAN, cnt <= CW'(TABLE_ENTRIES), "scan ran past the table")
  `AKT_ASSERT_IMP(a_miss_reads_zero, res_push && !q_hit, res.read_addr == '0 && res.read_status == '0, "read fields not zero without a query hit")

endmodule

`default_nettype wire

// File: verif/address_keyed_table_with_aging_core_test.sv
// Self-checking testbench for address_keyed_table_with_aging_core.
// Depends on akt_pkg and the table RTL; a scoreboard class predicts every result
// and plain tasks drive the request queue while an always block pops results.

// Keeps a private copy of the table and the timeout, works out the result of
// each accepted request and checks the results in order.
class table_scoreboard;
  logic [31:0]        timeout_ms;
  bit                 slot_active [akt_pkg::TABLE_ENTRIES_DEF];
  logic [47:0]        slot_addr   [akt_pkg::TABLE_ENTRIES_DEF];
  logic [7:0]         slot_type   [akt_pkg::TABLE_ENTRIES_DEF];
  logic signed [7:0]  slot_level  [akt_pkg::TABLE_ENTRIES_DEF];
  logic [63:0]        slot_status [akt_pkg::TABLE_ENTRIES_DEF];
  logic [31:0]        slot_seen   [akt_pkg::TABLE_ENTRIES_DEF];
  akt_pkg::out_item_t expected_q[$];
  int mismatches;
  int results_checked;
  int aged_out;
  int full_overwrites;
  int op_seen [4];

  function new();
    timeout_ms = akt_pkg::TIMEOUT_RESET;
    foreach (slot_active[i]) begin
      slot_active[i] = 1'b0;
      slot_addr[i]   = '0;
      slot_type[i]   = '0;
      slot_level[i]  = '0;
      slot_status[i] = '0;
      slot_seen[i]   = '0;
    end
    foreach (op_seen[i]) op_seen[i] = 0;
    mismatches      = 0;
    results_checked = 0;
    aged_out        = 0;
    full_overwrites = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH (result %0d): %s", results_checked, what);
  endtask

  // Applies one accepted request to the table copy and queues its result.
  function void note_request(input akt_pkg::in_item_t req);
    akt_pkg::out_item_t res;
    int slot;
    int live;
    logic [31:0] age;
    res  = '0;
    slot = -1;
    live = 0;
    op_seen[req.opcode]++;
    case (req.opcode)
      akt_pkg::OP_STORE: begin
        // An active entry with the same address wins, then the lowest free slot.
        for (int i = 0; i < akt_pkg::TABLE_ENTRIES_DEF; i++)
          if (slot < 0 && slot_active[i] && slot_addr[i] == req.dev_addr) slot = i;
        for (int i = 0; i < akt_pkg::TABLE_ENTRIES_DEF; i++)
          if (slot < 0 && !slot_active[i]) slot = i;
        if (slot < 0) begin
          slot = 0;
          full_overwrites++;
        end
        slot_active[slot] = 1'b1;
        slot_seen[slot]   = req.now_ms;
        slot_addr[slot]   = req.dev_addr;
        slot_type[slot]   = req.dev_addr_type;
        slot_level[slot]  = req.signal_level;
        slot_status[slot] = req.status_word;
        res.ok        = 1'b1;
        res.slot_used = 3'(slot);
      end
      akt_pkg::OP_SWEEP: begin
        if (timeout_ms != 32'd0) begin
          for (int i = 0; i < akt_pkg::TABLE_ENTRIES_DEF; i++) begin
            age = req.now_ms - slot_seen[i];
            if (slot_active[i] && age > timeout_ms) begin
              slot_active[i] = 1'b0;
              aged_out++;
            end
          end
        end
        res.ok = 1'b1;
      end
      akt_pkg::OP_QUERY: begin
        res.slot_used = req.entry_index;
        if (req.entry_index < akt_pkg::TABLE_ENTRIES_DEF && slot_active[req.entry_index]) begin
          res.ok             = 1'b1;
          res.read_addr      = slot_addr[req.entry_index];
          res.read_addr_type = slot_type[req.entry_index];
          res.read_level     = slot_level[req.entry_index];
          res.read_status    = slot_status[req.entry_index];
        end
      end
      default: begin
      end
    endcase
    foreach (slot_active[i]) if (slot_active[i]) live++;
    res.active_count = 4'(live);
    expected_q.push_back(res);
  endfunction

  task check_result(input akt_pkg::out_item_t got);
    akt_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result arrived with no request outstanding");
      return;
    end
    want = expected_q.pop_front();
    results_checked++;
    if (got.ok !== want.ok)
      report_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
    if (got.slot_used !== want.slot_used)
      report_mismatch($sformatf("slot_used %0d, expected %0d", got.slot_used, want.slot_used));
    if (got.active_count !== want.active_count)
      report_mismatch($sformatf("active_count %0d, expected %0d",
                                got.active_count, want.active_count));
    if (got.read_addr !== want.read_addr)
      report_mismatch($sformatf("read_addr %h, expected %h", got.read_addr, want.read_addr));
    if (got.read_addr_type !== want.read_addr_type)
      report_mismatch($sformatf("read_addr_type %h, expected %h",
                                got.read_addr_type, want.read_addr_type));
    if (got.read_level !== want.read_level)
      report_mismatch($sformatf("read_level %0d, expected %0d",
                                got.read_level, want.read_level));
    if (got.read_status !== want.read_status)
      report_mismatch($sformatf("read_status %h, expected %h",
                                got.read_status, want.read_status));
  endtask
endclass

module address_keyed_table_with_aging_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 is not decoded by the block; it must leave the table untouched.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ADDR_POOL_SIZE = 12;
  localparam int PHASE_REQUESTS = 160;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  logic               cfg_we = 1'b0;
  logic [31:0]        cfg_wdata = '0;
  akt_pkg::in_item_t  in_item = '0;
  akt_pkg::out_item_t out_item;

  table_scoreboard sb = new();

  // Stimulus state: a free-running millisecond clock, the largest step it
  // takes per request, and a small pool of addresses so that stores hit
  // existing entries and the table overflows regularly.
  logic [31:0] clock_ms = '0;
  int          step_ms = 1000;
  logic [47:0] addr_pool [ADDR_POOL_SIZE];
  int          settings_used = 0;

  // Receiver stall pattern state.
  int stall_mode = 0;
  int stall_left = 0;

  address_keyed_table_with_aging_core u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Both handshakes are sampled at the rising edge, before any of the
  // nonblocking updates of that edge take effect.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_request(in_item);
      if (pop && !empty) sb.check_result(out_item);
    end
  end

  // The receiver switches between popping every cycle, random popping,
  // mostly stalling and long stalls, each for a random stretch of cycles.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 1);
      2: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= (stall_left < 3);
    endcase
  end

  // Holds one request on the port until the block takes it. On return the
  // caller sits at the accepting edge, so a following request keeps push high.
  task automatic send_request(input akt_pkg::in_item_t req);
    push    <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic pause(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending and waits until every outstanding result has been checked.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Only called with the block idle; the scoreboard copy changes at the
  // same edge as the register.
  task automatic write_timeout(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.timeout_ms = value;
    settings_used++;
  endtask

  function automatic akt_pkg::in_item_t make_request(input logic [1:0] op,
                                                     input logic [31:0] now,
                                                     input logic [47:0] addr,
                                                     input logic [7:0] atype,
                                                     input logic signed [7:0] level,
                                                     input logic [63:0] status,
                                                     input logic [2:0] idx);
    akt_pkg::in_item_t req;
    req.opcode        = op;
    req.now_ms        = now;
    req.dev_addr      = addr;
    req.dev_addr_type = atype;
    req.signal_level  = level;
    req.status_word   = status;
    req.entry_index   = idx;
    return req;
  endfunction

  // Mostly small forward steps of the clock so that ages land around the
  // timeout; now and then a jump to anywhere, which can also move time backward.
  function automatic akt_pkg::in_item_t random_request();
    akt_pkg::in_item_t req;
    int pick;
    if ($urandom_range(0, 99) < 5) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, step_ms);
    pick = $urandom_range(0, 99);
    if (pick < 55) req.opcode = akt_pkg::OP_STORE;
    else if (pick < 75) req.opcode = akt_pkg::OP_SWEEP;
    else if (pick < 97) req.opcode = akt_pkg::OP_QUERY;
    else req.opcode = OP_UNUSED;
    req.now_ms = clock_ms;
    if ($urandom_range(0, 9) == 0) req.dev_addr = {16'($urandom()), $urandom()};
    else req.dev_addr = addr_pool[$urandom_range(0, ADDR_POOL_SIZE - 1)];
    req.dev_addr_type = 8'($urandom());
    req.signal_level  = 8'($urandom());
    req.status_word   = {$urandom(), $urandom()};
    req.entry_index   = 3'($urandom());
    return req;
  endfunction

  // One timeout setting: drain, write the register, then random bursts.
  task automatic run_phase(input logic [31:0] tmo, input bit near_wrap);
    int sent;
    int burst;
    sent = 0;
    drain();
    write_timeout(tmo);
    step_ms = (tmo == 32'd0 || tmo > 32'd1000000) ? 50000 : int'(tmo / 3) + 1;
    if (near_wrap) clock_ms = 32'hFFFF_FF00;
    addr_pool[$urandom_range(0, ADDR_POOL_SIZE - 1)] = {16'($urandom()), $urandom()};
    while (sent < PHASE_REQUESTS) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst; i++) begin
        send_request(random_request());
        sent++;
      end
      // About a quarter of the bursts run straight into the next one.
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [31:0] phase_timeouts [7];
    foreach (addr_pool[i]) addr_pool[i] = {16'($urandom()), $urandom()};
    phase_timeouts = '{32'd0, 32'd1, 32'd40, akt_pkg::TIMEOUT_RESET, 32'hFFFF_FFFF,
                       32'($urandom_range(2, 2000)), 32'd300};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the reset timeout of 480000 ms.
    // A query of an empty table and an undecoded opcode with every field at its top.
    send_request(make_request(akt_pkg::OP_QUERY, 32'd0, 48'd0, 8'd0, 8'sd0, 64'd0, 3'd0));
    send_request(make_request(OP_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF, -8'sd1,
                              64'hFFFF_FFFF_FFFF_FFFF, 3'd7));
    // Extreme field values; the second store's time has wrapped past zero.
    send_request(make_request(akt_pkg::OP_STORE, 32'hFFFF_FFF0, 48'hFFFF_FFFF_FFFF, 8'hFF,
                              -8'sd128, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7));
    send_request(make_request(akt_pkg::OP_STORE, 32'd5, 48'd0, 8'd0, 8'sd127, 64'd0, 3'd0));
    // Fill the remaining six slots at times 10 through 60.
    for (int k = 2; k < 8; k++)
      send_request(make_request(akt_pkg::OP_STORE, 32'(10 * (k - 1)),
                                48'h0000_1000_0000 + 48'(k), 8'(k), 8'(k * 3),
                                {32'(k), 32'hCAFE_0000}, 3'd0));
    // New address into a full table overwrites slot 0.
    send_request(make_request(akt_pkg::OP_STORE, 32'd70, 48'hA5A5_5A5A_0F0F, 8'h01, -8'sd5,
                              64'h0123_4567_89AB_CDEF, 3'd0));
    // Matching address updates its own slot in place.
    send_request(make_request(akt_pkg::OP_STORE, 32'd80, 48'd0, 8'h02, 8'sd3,
                              64'h0000_0000_DEAD_BEEF, 3'd0));
    send_request(make_request(akt_pkg::OP_QUERY, 32'd81, 48'd0, 8'd0, 8'sd0, 64'd0, 3'd0));
    send_request(make_request(akt_pkg::OP_QUERY, 32'd82, 48'd0, 8'd0, 8'sd0, 64'd0, 3'd1));
    send_request(make_request(akt_pkg::OP_QUERY, 32'd83, 48'd0, 8'd0, 8'sd0, 64'd0, 3'd7));
    // Ages of 480020 and 480010 go; the entry aged exactly 480000 stays.
    send_request(make_request(akt_pkg::OP_SWEEP, 32'd480030, 48'd0, 8'd0, 8'sd0, 64'd0,
                              3'd0));
    send_request(make_request(akt_pkg::OP_QUERY, 32'd480031, 48'd0, 8'd0, 8'sd0, 64'd0,
                              3'd2));
    // The freed slot is the lowest free one for a new address.
    send_request(make_request(akt_pkg::OP_STORE, 32'd480040, 48'h8000_0000_0001, 8'h80,
                              -8'sd64, 64'h8000_0000_0000_0001, 3'd0));
    send_request(make_request(akt_pkg::OP_QUERY, 32'd480041, 48'd0, 8'd0, 8'sd0, 64'd0,
                              3'd2));
    send_request(make_request(akt_pkg::OP_QUERY, 32'd480042, 48'd0, 8'd0, 8'sd0, 64'd0,
                              3'd4));
    // A timeout of zero disables aging entirely, even for huge ages.
    drain();
    write_timeout(32'd0);
    send_request(make_request(akt_pkg::OP_SWEEP, 32'h8000_0000, 48'd0, 8'd0, 8'sd0, 64'd0,
                              3'd0));
    send_request(make_request(akt_pkg::OP_QUERY, 32'h8000_0001, 48'd0, 8'd0, 8'sd0, 64'd0,
                              3'd3));
    // With the largest timeout no age can exceed it.
    drain();
    write_timeout(32'hFFFF_FFFF);
    send_request(make_request(akt_pkg::OP_SWEEP, 32'h7FFF_FFFF, 48'd0, 8'd0, 8'sd0, 64'd0,
                              3'd0));

    // Random part: one phase per timeout setting.
    foreach (phase_timeouts[p]) run_phase(phase_timeouts[p], p == 3);

    drain();
    repeat (2 * akt_pkg::TABLE_ENTRIES_DEF + 10) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("expected results left over at the end");

    $display("Covered %0d stores, %0d sweeps, %0d queries, %0d undecoded requests",
             sb.op_seen[akt_pkg::OP_STORE], sb.op_seen[akt_pkg::OP_SWEEP],
             sb.op_seen[akt_pkg::OP_QUERY], sb.op_seen[OP_UNUSED]);
    $display("over %0d timeouts; %0d results checked, %0d aged out, %0d full-table stores.",
             settings_used, sb.results_checked, sb.aged_out, sb.full_overwrites);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
